// ===== hdl/framed_param_receiver_mailbox_defines.svh =====
// assertion macros used by the receiver mailbox top level
`ifndef FRAMED_PARAM_RECEIVER_MAILBOX_DEFINES_SVH
`define FRAMED_PARAM_RECEIVER_MAILBOX_DEFINES_SVH

// condition that must hold in the same cycle as its trigger
`define FRPM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frpm same-cycle check failed");

// condition that must hold in the cycle after its trigger
`define FRPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frpm next-cycle check failed");

`endif

// ===== hdl/frpm_pkg.sv =====
// shared types and constants of the framed parameter receiver mailbox
package frpm_pkg;

    localparam logic [7:0] START_BYTE    = 8'h02;
    localparam logic [7:0] END_BYTE      = 8'h03;
    localparam logic [7:0] MAX_LEN_RESET = 8'd128;

    // decoder phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ARMH  = 3'd1;
    localparam logic [2:0] PH_ARML  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    // item kinds
    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_FETCH   = 1'b1;

    typedef struct packed {
        logic       is_fetch;
        logic [7:0] rx_byte;
        logic [7:0] query_address;
    } t_item;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  length;
        logic [7:0]  count;
        logic [7:0]  param_addr;
        logic [7:0]  sum;
        logic [7:0]  prev_byte;
        logic [31:0] value;
        logic [7:0]  arm_high;
    } t_slot;

    typedef struct packed {
        logic        found;
        logic [7:0]  param_address;
        logic [31:0] param_value;
        logic [4:0]  frames_saved;
        logic [4:0]  checksum_failures;
        logic [4:0]  stored_entries;
    } t_result;

endpackage

// ===== hdl/frpm_if.sv =====
// item channels of the receiver mailbox
interface frpm_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] query_address;
    modport source (output valid, action, rx_byte, query_address, input ready);
    modport sink (input valid, action, rx_byte, query_address, output ready);
endinterface

interface frpm_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  param_address;
    logic [31:0] param_value;
    logic [4:0]  frames_saved;
    logic [4:0]  checksum_failures;
    logic [4:0]  stored_entries;
    modport source (output valid, found, param_address, param_value, frames_saved,
                    checksum_failures, stored_entries, input ready);
    modport sink (input valid, found, param_address, param_value, frames_saved,
                  checksum_failures, stored_entries, output ready);
endinterface

// ===== hdl/framed_param_receiver_mailbox.sv =====
// framed parameter receiver with mailbox store: top level
// Input channel i_in carries one item: action 0 feeds one serial byte to the
// frame decoders, action 1 fetches the oldest stored parameter with the given
// address. Every item gives exactly one result on o_out.
// Items enter a two-entry queue, so a new item is taken while the engine works
// or while a result waits. The engine handles one item at a time.
// A byte item walks the open decoder slots in turn; a fetch item walks the
// stored entries through the store read port with a registered read.
// max_data_length is written over the APB port at addresses 0 to 3 (reset 128).
// Reset closes all decoders and empties the store.
// When o_out is stalled the result is held; the engine finishes the next item
// and waits, and the queue keeps taking items until it is full.
`include "framed_param_receiver_mailbox_defines.svh"
module framed_param_receiver_mailbox #(
    parameter int DECODER_SLOTS = 16,
    parameter int STORE_DEPTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frpm_in_if.sink     i_in,
    frpm_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0]        r_max_len;
    frpm_pkg::t_item   item;
    logic              item_valid;
    logic              item_ready;
    frpm_pkg::t_result res;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (!paddr[2]) ? {24'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= frpm_pkg::MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_max_len <= pwdata[7:0];
        end
    end

    frpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_item  (item),
        .o_valid (item_valid),
        .i_ready (item_ready)
    );

    frpm_back #(
        .DECODER_SLOTS (DECODER_SLOTS),
        .STORE_DEPTH   (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_len   (r_max_len),
        .i_item      (item),
        .i_valid     (item_valid),
        .o_ready     (item_ready),
        .o_res       (res),
        .o_res_valid (o_out.valid),
        .i_res_ready (o_out.ready)
    );

    // result fields
    assign o_out.found             = res.found;
    assign o_out.param_address     = res.param_address;
    assign o_out.param_value       = res.param_value;
    assign o_out.frames_saved      = res.frames_saved;
    assign o_out.checksum_failures = res.checksum_failures;
    assign o_out.stored_entries    = res.stored_entries;

    // checks
    `FRPM_ASSERT_SAME(a_miss_zero, o_out.valid && !o_out.found, o_out.param_address == 8'd0 && o_out.param_value == 32'd0)
    `FRPM_ASSERT_SAME(a_fetch_no_count, o_out.valid && o_out.found, o_out.frames_saved == 5'd0 && o_out.checksum_failures == 5'd0)
    `FRPM_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && !paddr[2], r_max_len == $past(pwdata[7:0]))
endmodule

// ===== hdl/frpm_front.sv =====
// front end: accepts and classifies items into a two-entry queue
module frpm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    frpm_in_if.sink          i_in,
    output frpm_pkg::t_item  o_item,
    output logic             o_valid,
    input  logic             i_ready
);
    frpm_pkg::t_item r_mem [2];
    logic            r_wp, n_wp;
    logic            r_rp, n_rp;
    logic [1:0]      r_cnt, n_cnt;
    logic            push, pop;
    frpm_pkg::t_item in_item;

    // classify the incoming item
    always_comb begin
        in_item.is_fetch      = (i_in.action == frpm_pkg::ACT_FETCH);
        in_item.rx_byte       = i_in.rx_byte;
        in_item.query_address = i_in.query_address;
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_item     = r_mem[r_rp];

    // queue pointers
    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_item;
        end
    end
endmodule

// ===== hdl/frpm_back.sv =====
// back end: walks decoder slots for a byte, or store entries for a fetch
module frpm_back #(
    parameter int DECODER_SLOTS = 16,
    parameter int STORE_DEPTH   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_max_len,
    input  frpm_pkg::t_item   i_item,
    input  logic              i_valid,
    output logic              o_ready,
    output frpm_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);
    localparam int SCW = $clog2(DECODER_SLOTS + 1);
    localparam int SIW = (DECODER_SLOTS > 1) ? $clog2(DECODER_SLOTS) : 1;
    localparam int FCW = $clog2(STORE_DEPTH + 1);
    localparam int STW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLOT = 3'd1;
    localparam logic [2:0] S_FREQ = 3'd2;
    localparam logic [2:0] S_FCHK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SCW-1:0]    r_active, n_active;
    logic [SCW-1:0]    r_k, n_k;
    logic [SCW-1:0]    r_kept, n_kept;
    logic [FCW-1:0]    r_fill, n_fill;
    logic [FCW-1:0]    r_fk, n_fk;
    logic              r_hit, n_hit;
    frpm_pkg::t_item   r_item, n_item;
    frpm_pkg::t_result r_res, n_res;
    frpm_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;

    frpm_pkg::t_slot   r_slots [DECODER_SLOTS];
    logic [39:0]       r_store [STORE_DEPTH];
    logic [39:0]       r_rd;

    logic              slot_we;
    logic [SIW-1:0]    slot_wa;
    frpm_pkg::t_slot   slot_wd;
    logic              st_we;
    logic [STW-1:0]    st_wa;
    logic [39:0]       st_wd;
    logic              st_re;

    frpm_pkg::t_slot   cur, nxt;
    logic              alive, append;
    logic [7:0]        b;
    logic [SCW-1:0]    base;
    logic [FCW:0]      fill_inc;

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;
    assign o_ready     = (r_state == S_IDLE);
    assign b           = r_item.rx_byte;
    assign cur         = r_slots[r_k[SIW-1:0]];
    assign fill_inc    = {1'b0, r_fill} + {{FCW{1'b0}}, 1'b1};

    // one decoder step on the current byte
    always_comb begin
        nxt    = cur;
        alive  = 1'b0;
        append = 1'b0;
        unique case (cur.phase)
            frpm_pkg::PH_START: begin
                nxt.phase = frpm_pkg::PH_ARMH;
                alive     = 1'b1;
            end
            frpm_pkg::PH_ARMH: begin
                nxt.arm_high = b;
                nxt.phase    = frpm_pkg::PH_ARML;
                alive        = 1'b1;
            end
            frpm_pkg::PH_ARML: begin
                nxt.phase = frpm_pkg::PH_LEN;
                alive     = 1'b1;
            end
            frpm_pkg::PH_LEN: begin
                nxt.length = b;
                nxt.phase  = frpm_pkg::PH_DATA;
                alive      = (b != 8'd0) && (b <= i_max_len);
            end
            frpm_pkg::PH_DATA: begin
                if (cur.count == 8'd0) begin
                    nxt.param_addr = b;
                    nxt.sum        = b;
                    nxt.value      = 32'd0;
                end else if (({1'b0, cur.count} + 9'd1) != {1'b0, cur.length}) begin
                    nxt.sum   = cur.sum + b;
                    nxt.value = {cur.value[23:0], b};
                end
                if (({1'b0, cur.count} + 9'd1) == {1'b0, cur.length}) begin
                    nxt.prev_byte = b;
                end
                nxt.count = cur.count + 8'd1;
                if (nxt.count >= cur.length) begin
                    nxt.phase = frpm_pkg::PH_END;
                end
                alive = 1'b1;
            end
            frpm_pkg::PH_END: begin
                append = (b == frpm_pkg::END_BYTE) && (cur.sum == cur.prev_byte);
            end
            default: begin
                alive = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_k         = r_k;
        n_kept      = r_kept;
        n_fill      = r_fill;
        n_fk        = r_fk;
        n_hit       = r_hit;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        slot_we     = 1'b0;
        slot_wa     = r_kept[SIW-1:0];
        slot_wd     = nxt;
        st_we       = 1'b0;
        st_wa       = r_fill[STW-1:0];
        st_wd       = {cur.param_addr, cur.value};
        st_re       = 1'b0;
        base        = (r_active >= SCW'(DECODER_SLOTS)) ? '0 : r_active;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = i_item;
                    n_res  = '0;
                    n_k    = '0;
                    n_kept = '0;
                    n_fk   = '0;
                    n_hit  = 1'b0;
                    if (i_item.is_fetch) begin
                        n_state = (r_fill != '0) ? S_FREQ : S_DONE;
                    end else begin
                        if (i_item.rx_byte == frpm_pkg::START_BYTE) begin
                            // open a new decoder, dropping all when full
                            slot_we       = 1'b1;
                            slot_wa       = base[SIW-1:0];
                            slot_wd       = '0;
                            slot_wd.phase = frpm_pkg::PH_START;
                            n_active      = base + SCW'(1);
                        end
                        n_state = (n_active != '0) ? S_SLOT : S_DONE;
                    end
                end
            end
            S_SLOT: begin
                if (alive) begin
                    slot_we = 1'b1;
                    n_kept  = r_kept + SCW'(1);
                end
                if (append) begin
                    st_we              = 1'b1;
                    n_fill             = (fill_inc >= (FCW+1)'(STORE_DEPTH)) ?
                                         '0 : fill_inc[FCW-1:0];
                    n_res.frames_saved = r_res.frames_saved + 5'd1;
                end else if (cur.phase == frpm_pkg::PH_END && b == frpm_pkg::END_BYTE) begin
                    n_res.checksum_failures = r_res.checksum_failures + 5'd1;
                end
                n_k = r_k + SCW'(1);
                if (n_k == r_active) begin
                    n_active = n_kept;
                    n_state  = S_DONE;
                end
            end
            S_FREQ: begin
                st_re   = 1'b1;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                // close the gap behind a hit, else look for a match
                if (r_hit) begin
                    st_we = 1'b1;
                    st_wa = r_fk[STW-1:0] - STW'(1);
                    st_wd = r_rd;
                end else if (r_rd[39:32] == r_item.query_address) begin
                    n_hit               = 1'b1;
                    n_res.found         = 1'b1;
                    n_res.param_address = r_rd[39:32];
                    n_res.param_value   = r_rd[31:0];
                end
                n_fk = r_fk + FCW'(1);
                if (n_fk == r_fill) begin
                    if (n_hit) begin
                        n_fill = r_fill - FCW'(1);
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_FREQ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out                = r_res;
                    n_out.stored_entries = 5'(r_fill);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_kept <= n_kept;
        r_fk   <= n_fk;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // decoder slot storage
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slots[slot_wa] <= slot_wd;
        end
    end

    // parameter store memory
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_rd <= r_store[r_fk[STW-1:0]];
        end
    end
endmodule
